FILE: src/crmt_pkg.sv
// Shared types and codes for the controller range mapping table.
package crmt_pkg;

    // Command codes carried in the func field
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_EVENT  = 2'd3;

    // Status codes of command results
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_ORD = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] cc_number;
        logic [6:0] cc_value;
        logic [6:0] in_low;
        logic [6:0] in_high;
        logic [7:0] target_id;
        logic [7:0] out_low;
        logic [7:0] out_high;
        logic [9:0] ordinal;
    } crmt_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] dest_id;
        logic [7:0] mapped_value;
        logic       is_event;
        logic       last_of_run;
    } crmt_result_t;

    // Classified command handed from the front queue to the sequencer
    typedef struct packed {
        logic       cc_ok;
        logic       tgt_ok;
        crmt_item_t item;
    } crmt_cmd_t;

    typedef struct packed {
        logic       vld;
        logic [6:0] in_low;
        logic [6:0] in_high;
        logic [7:0] target_id;
        logic [7:0] out_low;
        logic [7:0] out_high;
    } crmt_entry_t;

endpackage

FILE: src/crmt_item_if.sv
// Input channel: valid/ready handshake carrying one command beat.
interface crmt_item_if import crmt_pkg::*; ();
    logic       valid;
    logic       ready;
    crmt_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/crmt_result_if.sv
// Output channel: valid/ready handshake carrying one result beat.
interface crmt_result_if import crmt_pkg::*; ();
    logic         valid;
    logic         ready;
    crmt_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/crmt_div.sv
// Radix-2 restoring divider, 32-bit dividend by 8-bit divisor, one bit a cycle.
module crmt_div import crmt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [7:0]  quotient
);

    logic [31:0] dvd_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  dsr_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [8:0]  rem_sh;
    logic        ge;
    logic [8:0]  rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], ge};
            rem_reg <= ge ? rem_sub[7:0] : rem_sh[7:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[7:0];

endmodule

FILE: src/crmt_front.sv
// Front end: accept and classify command beats into a two-entry queue.
module crmt_front import crmt_pkg::*; #(
    parameter int CONTROLLERS = 128,
    parameter int TARGETS     = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    crmt_item_if.sink       item,
    input  logic            init_busy,
    input  logic            cmd_pop,
    output logic            cmd_vld,
    output crmt_cmd_t       cmd
);

    crmt_cmd_t  q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    crmt_cmd_t  cls;

    // Range checks resolved here so the sequencer only branches
    always_comb
    begin
        cls.item   = item.data;
        cls.cc_ok  = {1'b0, item.data.cc_number} < 8'(CONTROLLERS);
        cls.tgt_ok = {1'b0, item.data.target_id} < 9'(TARGETS);
    end

    assign item.ready = (fill_reg != 2'd2) && !init_busy;
    assign push       = item.valid && item.ready;
    assign cmd_vld    = fill_reg != 2'd0;
    assign cmd        = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !cmd_pop)
                fill_reg <= fill_reg + 2'd1;
            else if (!push && cmd_pop)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= cls;
    end

endmodule

FILE: src/crmt_back.sv
// Back end: table memory, command sequencer, scaling and the result register.
module crmt_back import crmt_pkg::*; #(
    parameter int CONTROLLERS          = 128,
    parameter int SLOTS_PER_CONTROLLER = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_vld,
    input  crmt_cmd_t       cmd,
    output logic            cmd_pop,
    output logic            init_busy,
    crmt_result_if.source   result
);

    localparam int CC_W   = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
    localparam int SLOT_W = (SLOTS_PER_CONTROLLER > 1) ? $clog2(SLOTS_PER_CONTROLLER) : 1;
    localparam int ADDR_W = CC_W + SLOT_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int CNT_W  = $clog2(CONTROLLERS * SLOTS_PER_CONTROLLER + 1);
    localparam int CMP_W  = (CNT_W > 10) ? CNT_W : 10;

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_CHK   = 10'b0000001000,
        S_WR    = 10'b0000010000,
        S_SCALE = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_PUT   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } state_t;

    crmt_entry_t mem [DEPTH];
    crmt_entry_t rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    crmt_entry_t       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    state_t            state_reg, state_next;
    logic [CC_W-1:0]   cc_reg, cc_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              free_found_reg, free_found_next;
    logic              clr_cmd_reg, clr_cmd_next;
    logic              hold_vld_reg, hold_vld_next;
    logic              res_vld_reg, res_vld_next;

    crmt_cmd_t         cur_reg, cur_next;
    crmt_entry_t       ent_reg, ent_next;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        hold_dest_reg, hold_dest_next;
    logic [7:0]        hold_val_reg, hold_val_next;
    logic [7:0]        new_val_reg, new_val_next;
    crmt_result_t      res_reg, res_next;

    logic              slot_last;
    logic              cc_last;
    logic              out_free;
    logic              found;
    logic [6:0]        diff;
    logic [31:0]       span;
    logic [31:0]       prod;
    logic [7:0]        den;
    logic              div_start;
    logic              div_done;
    logic [7:0]        div_q;

    crmt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mem_raddr = {cc_reg, slot_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign slot_last = slot_reg == SLOT_W'(SLOTS_PER_CONTROLLER - 1);
    assign cc_last   = cc_reg == CC_W'(CONTROLLERS - 1);
    assign out_free  = !res_vld_reg || result.ready;
    assign init_busy = (state_reg == S_CLR) && !clr_cmd_reg;

    assign diff = cur_reg.item.cc_value - ent_reg.in_low;
    assign span = 32'(ent_reg.out_high) - 32'(ent_reg.out_low) + 32'd1;
    assign prod = 32'(32'(diff) * span);
    assign den  = 8'(ent_reg.in_high) - 8'(ent_reg.in_low) + 8'd1;

    always_comb
    begin
        state_next      = state_reg;
        cc_next         = cc_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        free_found_next = free_found_reg;
        clr_cmd_next    = clr_cmd_reg;
        hold_vld_next   = hold_vld_reg;
        res_vld_next    = res_vld_reg && !result.ready;
        cur_next        = cur_reg;
        ent_next        = ent_reg;
        free_slot_next  = free_slot_reg;
        status_next     = status_reg;
        hold_dest_next  = hold_dest_reg;
        hold_val_next   = hold_val_reg;
        new_val_next    = new_val_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = {cc_reg, slot_reg};
        mem_wdata       = '0;
        div_start       = 1'b0;
        cmd_pop         = 1'b0;
        found           = free_found_reg || !rd_data_reg.vld;

        case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
                if (slot_last)
                begin
                    slot_next = '0;
                    if (cc_last)
                    begin
                        cc_next     = '0;
                        cnt_next    = '0;
                        status_next = ST_OK;
                        state_next  = clr_cmd_reg ? S_RESP : S_IDLE;
                    end
                    else
                        cc_next = cc_reg + CC_W'(1);
                end
                else
                    slot_next = slot_reg + SLOT_W'(1);
            end
            S_IDLE:
            begin
                if (cmd_vld)
                begin
                    cmd_pop         = 1'b1;
                    cur_next        = cmd;
                    slot_next       = '0;
                    cc_next         = '0;
                    n_next          = '0;
                    free_found_next = 1'b0;
                    hold_vld_next   = 1'b0;
                    case (cmd.item.func)
                        FUNC_ADD:
                        begin
                            cc_next = cmd.item.cc_number[CC_W-1:0];
                            if (!cmd.cc_ok || !cmd.tgt_ok)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                                state_next = S_RD;
                        end
                        FUNC_REMOVE:
                        begin
                            if (CMP_W'(cmd.item.ordinal) >= CMP_W'(cnt_reg))
                            begin
                                status_next = ST_BAD_ORD;
                                state_next  = S_RESP;
                            end
                            else
                                state_next = S_RD;
                        end
                        FUNC_CLEAR:
                        begin
                            clr_cmd_next = 1'b1;
                            state_next   = S_CLR;
                        end
                        FUNC_EVENT:
                        begin
                            cc_next = cmd.item.cc_number[CC_W-1:0];
                            // An out-of-range controller gives no result at all
                            state_next = cmd.cc_ok ? S_RD : S_IDLE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                case (cur_reg.item.func)
                    FUNC_ADD:
                    begin
                        if (rd_data_reg.vld && rd_data_reg.target_id == cur_reg.item.target_id)
                        begin
                            status_next = ST_DUP;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            if (!free_found_reg && !rd_data_reg.vld)
                            begin
                                free_found_next = 1'b1;
                                free_slot_next  = slot_reg;
                            end
                            if (slot_last)
                            begin
                                if (found)
                                    state_next = S_WR;
                                else
                                begin
                                    status_next = ST_FULL;
                                    state_next  = S_RESP;
                                end
                            end
                            else
                            begin
                                slot_next  = slot_reg + SLOT_W'(1);
                                state_next = S_RD;
                            end
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (rd_data_reg.vld && CMP_W'(n_reg) == CMP_W'(cur_reg.item.ordinal))
                        begin
                            mem_we      = 1'b1;
                            cnt_next    = cnt_reg - CNT_W'(1);
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            if (rd_data_reg.vld)
                                n_next = n_reg + CNT_W'(1);
                            if (slot_last && cc_last)
                            begin
                                status_next = ST_BAD_ORD;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RD;
                                if (slot_last)
                                begin
                                    slot_next = '0;
                                    cc_next   = cc_reg + CC_W'(1);
                                end
                                else
                                    slot_next = slot_reg + SLOT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        if (rd_data_reg.vld)
                        begin
                            ent_next   = rd_data_reg;
                            state_next = S_SCALE;
                        end
                        else if (slot_last)
                            state_next = S_FIN;
                        else
                        begin
                            slot_next  = slot_reg + SLOT_W'(1);
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_WR:
            begin
                mem_we              = 1'b1;
                mem_waddr           = {cc_reg, free_slot_reg};
                mem_wdata.vld       = 1'b1;
                mem_wdata.in_low    = cur_reg.item.in_low;
                mem_wdata.in_high   = cur_reg.item.in_high;
                mem_wdata.target_id = cur_reg.item.target_id;
                mem_wdata.out_low   = cur_reg.item.out_low;
                mem_wdata.out_high  = cur_reg.item.out_high;
                cnt_next            = cnt_reg + CNT_W'(1);
                status_next         = ST_OK;
                state_next          = S_RESP;
            end
            S_SCALE:
            begin
                if (cur_reg.item.cc_value <= ent_reg.in_low)
                begin
                    new_val_next = ent_reg.out_low;
                    state_next   = S_PUT;
                end
                else if (cur_reg.item.cc_value >= ent_reg.in_high)
                begin
                    new_val_next = ent_reg.out_high;
                    state_next   = S_PUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    new_val_next = div_q + ent_reg.out_low;
                    state_next   = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!hold_vld_reg || out_free)
                begin
                    if (hold_vld_reg)
                    begin
                        res_vld_next         = 1'b1;
                        res_next.status      = ST_OK;
                        res_next.dest_id     = hold_dest_reg;
                        res_next.mapped_value = hold_val_reg;
                        res_next.is_event    = 1'b1;
                        res_next.last_of_run = 1'b0;
                    end
                    hold_vld_next  = 1'b1;
                    hold_dest_next = ent_reg.target_id;
                    hold_val_next  = new_val_reg;
                    if (slot_last)
                        state_next = S_FIN;
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (!hold_vld_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    res_vld_next          = 1'b1;
                    res_next.status       = ST_OK;
                    res_next.dest_id      = hold_dest_reg;
                    res_next.mapped_value = hold_val_reg;
                    res_next.is_event     = 1'b1;
                    res_next.last_of_run  = 1'b1;
                    hold_vld_next         = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    res_vld_next          = 1'b1;
                    res_next.status       = status_reg;
                    res_next.dest_id      = '0;
                    res_next.mapped_value = '0;
                    res_next.is_event     = 1'b0;
                    res_next.last_of_run  = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cc_reg         <= '0;
            slot_reg       <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            free_found_reg <= 1'b0;
            clr_cmd_reg    <= 1'b0;
            hold_vld_reg   <= 1'b0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cc_reg         <= cc_next;
            slot_reg       <= slot_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            free_found_reg <= free_found_next;
            clr_cmd_reg    <= clr_cmd_next;
            hold_vld_reg   <= hold_vld_next;
            res_vld_reg    <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        ent_reg       <= ent_next;
        free_slot_reg <= free_slot_next;
        status_reg    <= status_next;
        hold_dest_reg <= hold_dest_next;
        hold_val_reg  <= hold_val_next;
        new_val_reg   <= new_val_next;
        res_reg       <= res_next;
    end

    assign result.valid = res_vld_reg;
    assign result.data  = res_reg;

endmodule

FILE: src/cc_range_mapping_table.sv
// Top level of the controller range mapping table.
//
// Channels: "item" takes command beats (add, remove by ordinal, clear,
// controller event); "result" gives result beats. Both use valid/ready and a
// beat moves on a clock edge where both are high. Add, remove and clear give
// one status beat each; an event gives one beat per valid slot of its row,
// the final one flagged by last_of_run, or none for an empty row.
// Sequencing: a two-entry queue takes beats while the sequencer works. Each
// slot visit has a memory read state and a check state. Add scans one row;
// remove walks the table row-major until it finds the ordinal; clear sweeps
// the whole table; an event visits each slot of its row and starts the
// serial divider for a valid slot whose value lies strictly between its bounds.
// Reset: a clearing pass writes every entry invalid; item.ready stays low
// until it ends.
// Stall: the result register holds a beat until taken; the sequencer waits,
// the queue fills, then item.ready drops.
module cc_range_mapping_table import crmt_pkg::*; #(
    parameter int CONTROLLERS          = 128,
    parameter int SLOTS_PER_CONTROLLER = 8,
    parameter int TARGETS              = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    crmt_item_if.sink       item,
    crmt_result_if.source   result
);

    logic      cmd_vld;
    logic      cmd_pop;
    logic      init_busy;
    crmt_cmd_t cmd;

    // Accept and classify beats, hold them for the sequencer
    crmt_front #(
        .CONTROLLERS (CONTROLLERS),
        .TARGETS     (TARGETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .init_busy (init_busy),
        .cmd_pop   (cmd_pop),
        .cmd_vld   (cmd_vld),
        .cmd       (cmd)
    );

    // Walk the table, scale and drive results
    crmt_back #(
        .CONTROLLERS          (CONTROLLERS),
        .SLOTS_PER_CONTROLLER (SLOTS_PER_CONTROLLER)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_vld   (cmd_vld),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .result    (result)
    );

`ifndef SYNTHESIS
    // No beat may enter while the reset clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n) init_busy |-> !item.ready)
        else $error("item accepted during clearing pass");

    // The sequencer only pops a queued command
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_vld)
        else $error("pop from empty command queue");

    // Right after reset the clearing pass must be running
    assert property (@(posedge clk) $rose(rst_n) |-> init_busy)
        else $error("clearing pass not started after reset");
`endif

endmodule

FILE: test/crmt_checker.sv
// Checker for the controller range mapping table: predicts and compares result beats.
module crmt_checker import crmt_pkg::*; #(
    parameter int CONTROLLERS          = 128,
    parameter int SLOTS_PER_CONTROLLER = 8,
    parameter int TARGETS              = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    crmt_item_if        item,
    crmt_result_if      result,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    crmt_entry_t  table_q [CONTROLLERS][SLOTS_PER_CONTROLLER];
    int           entry_total;
    crmt_result_t expected_beats [$];

    function automatic logic [7:0] scaled_value(crmt_entry_t e, logic [6:0] v);
        logic [31:0] num;
        logic [31:0] den;
        if (v <= e.in_low)
            return e.out_low;
        if (v >= e.in_high)
            return e.out_high;
        num = (32'(v) - 32'(e.in_low)) * (32'(e.out_high) - 32'(e.out_low) + 32'd1);
        den = 32'(e.in_high) - 32'(e.in_low) + 32'd1;
        return 8'(num / den + 32'(e.out_low));
    endfunction

    function automatic crmt_result_t status_beat(logic [1:0] st);
        crmt_result_t r;
        r = '0;
        r.status = st;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    // Apply one accepted command beat to the shadow table and queue its results.
    task automatic predict_beat(crmt_item_t it);
        logic [1:0]   st;
        int           n;
        int           first_free;
        int           last_idx;
        crmt_result_t r;
        st = ST_OK;
        case (it.func)
            FUNC_ADD:
            begin
                first_free = -1;
                if (it.cc_number >= CONTROLLERS || it.target_id >= TARGETS)
                    st = ST_FULL;
                else
                begin
                    for (int s = 0; s < SLOTS_PER_CONTROLLER; s++)
                    begin
                        if (table_q[it.cc_number][s].vld
                            && table_q[it.cc_number][s].target_id == it.target_id)
                            st = ST_DUP;
                        if (!table_q[it.cc_number][s].vld && first_free < 0)
                            first_free = s;
                    end
                    if (st == ST_OK && first_free < 0)
                        st = ST_FULL;
                    if (st == ST_OK)
                    begin
                        table_q[it.cc_number][first_free] = '{1'b1, it.in_low, it.in_high,
                            it.target_id, it.out_low, it.out_high};
                        entry_total++;
                    end
                end
                expected_beats.push_back(status_beat(st));
            end
            FUNC_REMOVE:
            begin
                st = ST_BAD_ORD;
                n = 0;
                if (it.ordinal < entry_total)
                    for (int c = 0; c < CONTROLLERS; c++)
                        for (int s = 0; s < SLOTS_PER_CONTROLLER; s++)
                            if (table_q[c][s].vld && st != ST_OK)
                            begin
                                if (n == it.ordinal)
                                begin
                                    table_q[c][s].vld = 1'b0;
                                    entry_total--;
                                    st = ST_OK;
                                end
                                n++;
                            end
                expected_beats.push_back(status_beat(st));
            end
            FUNC_CLEAR:
            begin
                foreach (table_q[c, s])
                    table_q[c][s].vld = 1'b0;
                entry_total = 0;
                expected_beats.push_back(status_beat(ST_OK));
            end
            default:
            begin
                last_idx = -1;
                if (it.cc_number < CONTROLLERS)
                    for (int s = 0; s < SLOTS_PER_CONTROLLER; s++)
                        if (table_q[it.cc_number][s].vld)
                        begin
                            r = '0;
                            r.dest_id = table_q[it.cc_number][s].target_id;
                            r.mapped_value = scaled_value(table_q[it.cc_number][s],
                                                          it.cc_value);
                            r.is_event = 1'b1;
                            expected_beats.push_back(r);
                            last_idx = expected_beats.size() - 1;
                        end
                if (last_idx >= 0)
                    expected_beats[last_idx].last_of_run = 1'b1;
            end
        endcase
    endtask

    task automatic compare_beat(crmt_result_t got);
        crmt_result_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected result beat %p", got);
            fail_count++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.dest_id !== want.dest_id)
        begin
            $error("dest_id: expected %0d, got %0d", want.dest_id, got.dest_id);
            fail_count++;
        end
        if (got.mapped_value !== want.mapped_value)
        begin
            $error("mapped_value: expected %0d, got %0d", want.mapped_value,
                   got.mapped_value);
            fail_count++;
        end
        if (got.is_event !== want.is_event)
        begin
            $error("is_event: expected %0d, got %0d", want.is_event, got.is_event);
            fail_count++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   got.last_of_run);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        entry_total = 0;
        foreach (table_q[c, s])
            table_q[c][s] = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Check the output first: a result never depends on the beat taken now.
            if (result.valid && result.ready)
                compare_beat(result.data);
            if (item.valid && item.ready)
                predict_beat(item.data);
        end
        pending_count = expected_beats.size();
    end
endmodule

FILE: test/cc_range_mapping_table_test.sv
// Top of the mapping table testbench: stimulus, stall control and verdict.
module cc_range_mapping_table_test;
    import crmt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   stall_left;

    crmt_item_if   item ();
    crmt_result_if result ();

    cc_range_mapping_table DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    crmt_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Half the time no gap, otherwise mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic crmt_item_t random_fields();
        crmt_item_t it;
        it = crmt_item_t'({$urandom, $urandom});
        return it;
    endfunction

    // Rows come from a small pool so adds collide, rows fill and events hit.
    function automatic crmt_item_t make_add(logic [6:0] cc, logic [7:0] tgt);
        crmt_item_t it;
        it = random_fields();
        it.func = FUNC_ADD;
        it.cc_number = cc;
        it.target_id = tgt;
        return it;
    endfunction

    function automatic crmt_item_t make_event(logic [6:0] cc, logic [6:0] v);
        crmt_item_t it;
        it = random_fields();
        it.func = FUNC_EVENT;
        it.cc_number = cc;
        it.cc_value = v;
        return it;
    endfunction

    function automatic crmt_item_t make_remove(logic [9:0] ord);
        crmt_item_t it;
        it = random_fields();
        it.func = FUNC_REMOVE;
        it.ordinal = ord;
        return it;
    endfunction

    // Present one beat, hold it until taken, then drop valid for a gap if the gap is not zero.
    task automatic send_beat(crmt_item_t it);
        int gap;
        item.data  <= it;
        item.valid <= 1'b1;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        gap = gap_length();
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver stalls, independent of the sender: mostly short, a few long.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            result.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            result.ready <= 1'b0;
            stall_left = $urandom_range(10, 60);
        end
        else
            result.ready <= ($urandom_range(0, 99) < 70);
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        crmt_item_t it;
        logic [6:0] row_pool [4];
        rst_n      = 1'b0;
        item.valid = 1'b0;
        item.data  = '0;
        result.ready = 1'b0;
        row_pool = '{7'd0, 7'd5, 7'd127, 7'd64};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table cases, fill a row, duplicates, extremes.
        it = make_remove(10'd0);
        send_beat(it);
        it = make_event(7'd3, 7'd50);
        send_beat(it);
        it = '0;
        it.func = FUNC_CLEAR;
        send_beat(it);
        for (int s = 0; s < 9; s++)
        begin
            it = make_add(7'd127, 8'(s * 31));
            it.in_low  = (s == 0) ? 7'd0 : 7'd20;
            it.in_high = (s == 0) ? 7'd127 : 7'd100;
            it.out_low  = (s == 1) ? 8'd255 : 8'd0;
            it.out_high = (s == 1) ? 8'd0 : 8'd255;
            send_beat(it);
        end
        it = make_add(7'd0, 8'd255);
        send_beat(it);
        it = make_add(7'd0, 8'd255);
        send_beat(it);
        it = make_event(7'd127, 7'd0);
        send_beat(it);
        it = make_event(7'd127, 7'd127);
        send_beat(it);
        it = make_event(7'd127, 7'd60);
        send_beat(it);
        it = make_event(7'd0, 7'd127);
        send_beat(it);
        it = make_remove(10'd1023);
        send_beat(it);
        it = make_remove(10'd8);
        send_beat(it);
        it = make_remove(10'd0);
        send_beat(it);
        it = make_event(7'd127, 7'd21);
        send_beat(it);

        // Random: mostly adds and events on a few rows, some removes and clears.
        for (int n = 0; n < 438; n++)
        begin
            int roll;
            roll = $urandom_range(0, 99);
            if (roll < 40)
                it = make_add(row_pool[$urandom_range(0, 3)], 8'($urandom_range(0, 11)
                              * ($urandom_range(0, 1) ? 23 : 1)));
            else if (roll < 80)
                it = make_event(row_pool[$urandom_range(0, 3)], 7'($urandom));
            else if (roll < 90)
                it = make_remove(($urandom_range(0, 3) == 0) ? 10'($urandom)
                                 : 10'($urandom_range(0, 20)));
            else if (roll < 93)
            begin
                it = random_fields();
                it.func = FUNC_CLEAR;
            end
            else
                it = random_fields();
            send_beat(it);
        end
        item.valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (2200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
